@@ hdl/dcfp_pkg.sv @@
// ----------------------------------------------------------------------------
// dcfp_pkg
// Shared types and constants of the delimited command frame parser: record
// ring geometry, operation and event codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dcfp_pkg;

    // record ring geometry
    localparam int NUM_RECORDS = 8;
    localparam int NUM_FIELDS  = 4;
    localparam int FIELD_BYTES = 16;
    localparam int REC_W       = 3;
    localparam int FLD_W       = 2;
    localparam int POS_W       = 4;
    localparam int ADDR_W      = REC_W + FLD_W + POS_W;
    localparam int STORE_DEPTH = NUM_RECORDS * NUM_FIELDS * FIELD_BYTES;

    localparam logic [REC_W-1:0]  REC_LAST  = REC_W'(NUM_RECORDS - 1);
    localparam logic [FLD_W-1:0]  FLD_LAST  = FLD_W'(NUM_FIELDS - 1);
    localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(FIELD_BYTES - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_DEPTH - 1);

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 4;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_DELIM = 2'd1;
    localparam logic [1:0] REG_END   = 2'd2;

    localparam logic [7:0] START_RESET = 8'd36;
    localparam logic [7:0] DELIM_RESET = 8'd44;
    localparam logic [7:0] END_RESET   = 8'd13;

    typedef enum logic [1:0] {
        FUNC_RX      = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        EV_IGNORED  = 4'd0,
        EV_STORED   = 4'd1,
        EV_FIELD    = 4'd2,
        EV_DONE     = 4'd3,
        EV_TOO_MANY = 4'd4,
        EV_OVERRUN  = 4'd5,
        EV_STARTED  = 4'd6,
        EV_READ     = 4'd7,
        EV_RELEASED = 4'd8
    } event_t;

    typedef enum logic [1:0] {
        REC_EMPTY  = 2'd0,
        REC_ACTIVE = 2'd1,
        REC_FULL   = 2'd2
    } rec_state_t;

    typedef enum logic [2:0] {
        CS_CLEAR,
        CS_IDLE,
        CS_ZERO,
        CS_READ,
        CS_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic [7:0] start_char;
        logic [7:0] delimiter_char;
        logic [7:0] end_char;
    } cfg_t;

    typedef struct packed {
        logic load;       // capture the incoming item
        logic clr_step;   // write one zero of the store clearing pass
        logic zero_step;  // zero the first byte of one field
        logic exec;       // apply the item and load the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;   // clearing pass at its last entry
        logic zero_last;  // field zeroing at its last field
        logic start_ok;   // incoming item opens a record
        logic is_read;    // incoming item is a read
        logic out_free;   // output register can take a result
    } dp_status_t;

endpackage

@@ hdl/delimited_command_frame_parser.sv @@
// ----------------------------------------------------------------------------
// delimited_command_frame_parser
// Files received serial bytes into a ring of framed command records and
// serves reads and releases of the stored records.
// ----------------------------------------------------------------------------
// Usage: items enter on the s_ stream; s_tuser selects a received byte, a
// read of a stored byte or a release of a record. Each item gives exactly
// one result on the m_ stream: the event code in m_tuser, the addressed
// record's status, the fill pointers and read data in m_tdata.
// Start, delimiter and end byte values sit in registers on the APB port
// (byte addresses 0, 4, 8); write them only while no item is in flight.
// Timing: one item at a time. A received data, delimiter or end byte or a
// release goes from acceptance to the final update; a read first waits for
// the registered memory read, a start byte opening a record first makes one
// zeroing write per field head on the single write port of the byte store.
// Reset: record states and pointers clear at once, then a clearing pass
// writes zeros to all 512 store entries, one per cycle; s_tready stays low
// throughout that pass. Registers can be written during that pass.
// Stall: a result waits in the output register; the next item is accepted
// meanwhile, and its result is held back until the output is taken.
// ----------------------------------------------------------------------------
module delimited_command_frame_parser (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: rx_byte[7:0], sel_record[10:8], sel_field[12:11],
    //          sel_position[16:13], zero fill
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dcfp_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: func[1:0]
    input  logic [dcfp_pkg::S_TUSER_W-1:0]    s_tuser,
    // m_tdata: record_status[1:0], active_record[4:2], field_index[6:5],
    //          char_index[10:7], read_data[18:11], zero fill
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dcfp_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: event_res[3:0]
    output logic [dcfp_pkg::M_TUSER_W-1:0]    m_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dcfp_pkg::PADDR_W-1:0]      paddr,
    input  logic [dcfp_pkg::PDATA_W-1:0]      pwdata,
    output logic [dcfp_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    dcfp_pkg::cfg_t       cfg;
    dcfp_pkg::ctrl_cmd_t  cmd;
    dcfp_pkg::dp_status_t status;

    // configuration registers
    dcfp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // controller
    dcfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    dcfp_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

@@ hdl/dcfp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dcfp_cfg_regs
// Register file behind the configuration port: start, delimiter and end
// byte values, written in the access phase and read back combinationally.
// ----------------------------------------------------------------------------
module dcfp_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcfp_pkg::PADDR_W-1:0]  paddr,
    input  logic [dcfp_pkg::PDATA_W-1:0]  pwdata,
    output logic [dcfp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output dcfp_pkg::cfg_t                cfg
);

    logic [7:0] start_reg;
    logic [7:0] delim_reg;
    logic [7:0] end_reg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[3:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= dcfp_pkg::START_RESET;
            delim_reg <= dcfp_pkg::DELIM_RESET;
            end_reg   <= dcfp_pkg::END_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                dcfp_pkg::REG_START: start_reg <= pwdata[7:0];
                dcfp_pkg::REG_DELIM: delim_reg <= pwdata[7:0];
                dcfp_pkg::REG_END:   end_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            dcfp_pkg::REG_START: prdata = {24'd0, start_reg};
            dcfp_pkg::REG_DELIM: prdata = {24'd0, delim_reg};
            dcfp_pkg::REG_END:   prdata = {24'd0, end_reg};
            default:             prdata = '0;
        endcase
    end

    assign cfg.start_char     = start_reg;
    assign cfg.delimiter_char = delim_reg;
    assign cfg.end_char       = end_reg;

endmodule

@@ hdl/dcfp_ctrl.sv @@
// ----------------------------------------------------------------------------
// dcfp_ctrl
// Controller: sequences the store clearing pass after reset, input
// acceptance, zeroing of the field heads on a start byte, the read wait
// and the final update that hands the result to the output register.
// ----------------------------------------------------------------------------
module dcfp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  dcfp_pkg::dp_status_t   status,
    output dcfp_pkg::ctrl_cmd_t    cmd
);

    dcfp_pkg::ctrl_state_t state_reg;
    dcfp_pkg::ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dcfp_pkg::CS_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            dcfp_pkg::CS_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = dcfp_pkg::CS_IDLE;
                end
            end
            dcfp_pkg::CS_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (status.start_ok)
                    begin
                        state_next = dcfp_pkg::CS_ZERO;
                    end
                    else if (status.is_read)
                    begin
                        state_next = dcfp_pkg::CS_READ;
                    end
                    else
                    begin
                        state_next = dcfp_pkg::CS_FINISH;
                    end
                end
            end
            dcfp_pkg::CS_ZERO:
            begin
                cmd.zero_step = 1'b1;
                if (status.zero_last)
                begin
                    state_next = dcfp_pkg::CS_FINISH;
                end
            end
            dcfp_pkg::CS_READ:
            begin
                state_next = dcfp_pkg::CS_FINISH;
            end
            dcfp_pkg::CS_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = dcfp_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = dcfp_pkg::CS_CLEAR;
            end
        endcase
    end

endmodule

@@ hdl/dcfp_dp.sv @@
// ----------------------------------------------------------------------------
// dcfp_dp
// Datapath: item register, record states, fill pointers, the byte store
// memory with its registered read port, and the output register.
// ----------------------------------------------------------------------------
module dcfp_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dcfp_pkg::cfg_t                    cfg,
    input  logic [dcfp_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [dcfp_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dcfp_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [dcfp_pkg::M_TUSER_W-1:0]    m_tuser,
    input  dcfp_pkg::ctrl_cmd_t               cmd,
    output dcfp_pkg::dp_status_t              status
);

    localparam int REC_W  = dcfp_pkg::REC_W;
    localparam int FLD_W  = dcfp_pkg::FLD_W;
    localparam int POS_W  = dcfp_pkg::POS_W;
    localparam int ADDR_W = dcfp_pkg::ADDR_W;

    // byte store
    logic [7:0] mem [dcfp_pkg::STORE_DEPTH];
    logic [7:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;

    // item register
    dcfp_pkg::func_t  it_func_reg;
    logic [7:0]       it_rx_reg;
    logic [REC_W-1:0] it_rec_reg;
    logic [FLD_W-1:0] it_fld_reg;
    logic [POS_W-1:0] it_pos_reg;

    // parser state
    dcfp_pkg::rec_state_t rs_reg   [dcfp_pkg::NUM_RECORDS];
    dcfp_pkg::rec_state_t rs_next  [dcfp_pkg::NUM_RECORDS];
    logic [REC_W-1:0]     cur_reg;
    logic [REC_W-1:0]     cur_next;
    logic [FLD_W-1:0]     fp_reg;
    logic [FLD_W-1:0]     fp_next;
    logic [POS_W-1:0]     cp_reg;
    logic [POS_W-1:0]     cp_next;

    // sequencing counters
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [FLD_W-1:0]  fcnt_reg;

    // output register
    logic                 out_valid_reg;
    dcfp_pkg::event_t     ev_reg;
    logic [1:0]           st_out_reg;
    logic [REC_W-1:0]     rec_out_reg;
    logic [FLD_W-1:0]     fld_out_reg;
    logic [POS_W-1:0]     pos_out_reg;
    logic [7:0]           data_out_reg;

    // exec results
    dcfp_pkg::event_t     ev_next;
    logic [1:0]           st_next;
    logic [7:0]           data_next;
    logic                 ex_we;
    logic [ADDR_W-1:0]    ex_addr;
    logic [7:0]           ex_wdata;

    // incoming item fields
    dcfp_pkg::func_t  in_func;
    logic [7:0]       in_rx;

    assign in_func = dcfp_pkg::func_t'(s_tuser[1:0]);
    assign in_rx   = s_tdata[7:0];

    // status to the controller
    assign status.clr_last  = (clr_cnt_reg == dcfp_pkg::ADDR_LAST);
    assign status.zero_last = (fcnt_reg == dcfp_pkg::FLD_LAST);
    assign status.start_ok  = (in_func == dcfp_pkg::FUNC_RX) &&
                              (in_rx == cfg.start_char) &&
                              (rs_reg[cur_reg] != dcfp_pkg::REC_FULL);
    assign status.is_read   = (in_func == dcfp_pkg::FUNC_READ);
    assign status.out_free  = !out_valid_reg || m_tready;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            it_func_reg <= in_func;
            it_rx_reg   <= in_rx;
            it_rec_reg  <= s_tdata[10:8];
            it_fld_reg  <= s_tdata[12:11];
            it_pos_reg  <= s_tdata[16:13];
        end
    end

    // item update: pointers, record states, store write and result
    always_comb
    begin
        rs_next   = rs_reg;
        cur_next  = cur_reg;
        fp_next   = fp_reg;
        cp_next   = cp_reg;
        ev_next   = dcfp_pkg::EV_IGNORED;
        st_next   = 2'd0;
        data_next = 8'd0;
        ex_we     = 1'b0;
        ex_addr   = {cur_reg, fp_reg, cp_reg};
        ex_wdata  = 8'd0;
        case (it_func_reg)
            dcfp_pkg::FUNC_RX:
            begin
                if (it_rx_reg == cfg.start_char)
                begin
                    if (rs_reg[cur_reg] != dcfp_pkg::REC_FULL)
                    begin
                        rs_next[cur_reg] = dcfp_pkg::REC_ACTIVE;
                        fp_next          = '0;
                        cp_next          = '0;
                        ev_next          = dcfp_pkg::EV_STARTED;
                    end
                end
                else if (rs_reg[cur_reg] != dcfp_pkg::REC_ACTIVE)
                begin
                    ev_next = dcfp_pkg::EV_IGNORED;
                end
                else if (it_rx_reg == cfg.delimiter_char)
                begin
                    if (fp_reg != dcfp_pkg::FLD_LAST)
                    begin
                        ex_we   = 1'b1;
                        fp_next = fp_reg + FLD_W'(1);
                        cp_next = '0;
                        ev_next = dcfp_pkg::EV_FIELD;
                    end
                    else
                    begin
                        rs_next[cur_reg] = dcfp_pkg::REC_EMPTY;
                        ev_next          = dcfp_pkg::EV_TOO_MANY;
                    end
                end
                else if (it_rx_reg == cfg.end_char)
                begin
                    ex_we            = 1'b1;
                    rs_next[cur_reg] = dcfp_pkg::REC_FULL;
                    cur_next         = (cur_reg == dcfp_pkg::REC_LAST) ? '0
                                                                       : cur_reg + REC_W'(1);
                    ev_next          = dcfp_pkg::EV_DONE;
                end
                else
                begin
                    ex_we    = 1'b1;
                    ex_wdata = it_rx_reg;
                    if (cp_reg != dcfp_pkg::POS_LAST)
                    begin
                        cp_next = cp_reg + POS_W'(1);
                        ev_next = dcfp_pkg::EV_STORED;
                    end
                    else
                    begin
                        rs_next[cur_reg] = dcfp_pkg::REC_EMPTY;
                        ev_next          = dcfp_pkg::EV_OVERRUN;
                    end
                end
                st_next = rs_next[cur_reg];
            end
            dcfp_pkg::FUNC_READ:
            begin
                ev_next   = dcfp_pkg::EV_READ;
                st_next   = rs_reg[it_rec_reg];
                data_next = rd_data_reg;
            end
            dcfp_pkg::FUNC_RELEASE:
            begin
                rs_next[it_rec_reg] = dcfp_pkg::REC_EMPTY;
                ev_next             = dcfp_pkg::EV_RELEASED;
                st_next             = dcfp_pkg::REC_EMPTY;
            end
            default:
            begin
                ev_next = dcfp_pkg::EV_IGNORED;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dcfp_pkg::NUM_RECORDS; i++)
            begin
                rs_reg[i] <= dcfp_pkg::REC_EMPTY;
            end
            cur_reg       <= '0;
            fp_reg        <= '0;
            cp_reg        <= '0;
            clr_cnt_reg   <= '0;
            fcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.load)
            begin
                fcnt_reg <= '0;
            end
            else if (cmd.zero_step)
            begin
                fcnt_reg <= fcnt_reg + FLD_W'(1);
            end
            if (cmd.exec)
            begin
                rs_reg  <= rs_next;
                cur_reg <= cur_next;
                fp_reg  <= fp_next;
                cp_reg  <= cp_next;
            end
            if (cmd.exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ev_reg       <= ev_next;
            st_out_reg   <= st_next;
            rec_out_reg  <= cur_next;
            fld_out_reg  <= fp_next;
            pos_out_reg  <= cp_next;
            data_out_reg <= data_next;
        end
    end

    // store write port select
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = ex_addr;
        mem_wdata = 8'd0;
        if (cmd.clr_step)
        begin
            mem_we   = 1'b1;
            mem_addr = clr_cnt_reg;
        end
        else if (cmd.zero_step)
        begin
            mem_we   = 1'b1;
            mem_addr = {cur_reg, fcnt_reg, POS_W'(0)};
        end
        else if (cmd.exec)
        begin
            mem_we    = ex_we;
            mem_wdata = ex_wdata;
        end
    end

    // byte store memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[{it_rec_reg, it_fld_reg, it_pos_reg}];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = ev_reg;
    assign m_tdata  = {5'd0, data_out_reg, pos_out_reg, fld_out_reg, rec_out_reg, st_out_reg};

endmodule
